// ----- src/egcd_pkg.sv -----
`default_nettype none

package egcd_pkg;

  // Fixed result field widths
  localparam int unsigned GcdW   = 16;
  localparam int unsigned CoefW  = 17;
  localparam int unsigned CountW = 5;
  localparam int unsigned InW    = 16;

  localparam logic [CountW-1:0] CountMax = 5'd31;

  // Controller -> datapath
  typedef struct packed {
    logic load;      // take a new operand pair
    logic div_init;  // clear remainder, load dividend
    logic div_step;  // one restoring division bit
    logic mul;       // register quotient * current coefficients
    logic upd;       // coefficient / operand update, restart divider
    logic out_load;  // capture result into the output register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic b_zero;    // divisor is zero
    logic r_zero;    // remainder of last division is zero
    logic div_last;  // final division bit this cycle
  } status_t;

endpackage

`default_nettype wire

// ----- src/egcd_ctrl.sv -----
`default_nettype none

module egcd_ctrl (
  input  wire                logic clk_i,
  input  wire                logic rst_ni,
  input  wire                logic in_valid_i,
  output                     logic in_ready_o,
  output                     logic out_valid_o,
  input  wire                logic out_ready_i,
  input  wire egcd_pkg::status_t  status_i,
  output      egcd_pkg::cmd_t     cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_TEST,
    S_UPD,
    S_HOLD
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.b_zero) begin
          state_d = S_HOLD;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = S_TEST;
      end
      S_TEST: begin
        if (status_i.r_zero) begin
          state_d = S_HOLD;
        end else begin
          cmd_o.mul = 1'b1;
          state_d   = S_UPD;
        end
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_DIV;
      end
      S_HOLD: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/egcd_datapath.sv -----
`default_nettype none

module egcd_datapath #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  wire                 logic clk_i,
  input  wire logic [egcd_pkg::InW-1:0]  first_value_i,
  input  wire logic [egcd_pkg::InW-1:0]  second_value_i,
  input  wire egcd_pkg::cmd_t            cmd_i,
  output      egcd_pkg::status_t         status_o,
  output      logic [egcd_pkg::GcdW-1:0]   gcd_value_o,
  output      logic signed [egcd_pkg::CoefW-1:0] coef_first_o,
  output      logic signed [egcd_pkg::CoefW-1:0] coef_second_o,
  output      logic [egcd_pkg::CountW-1:0] step_count_o
);

  localparam int unsigned W    = OPERAND_WIDTH;
  localparam int unsigned CntW = (W > 1) ? $clog2(W) : 1;
  localparam int unsigned CW   = egcd_pkg::CoefW;
  localparam logic [CntW-1:0] CntLast = CntW'(W - 1);

  logic [W-1:0]    a_q, b_q;
  logic [W-1:0]    rem_q, quo_q;
  logic [CntW-1:0] cnt_q;
  logic [CW-1:0]   up_q, vp_q, uc_q, vc_q;
  logic [CW-1:0]   pu_q, pv_q;
  logic [egcd_pkg::CountW-1:0] steps_q;

  logic [egcd_pkg::GcdW-1:0]   gcd_q;
  logic [CW-1:0]               cf_q, cs_q;
  logic [egcd_pkg::CountW-1:0] sc_q;

  logic [W:0] rem_sh, diff;
  logic [CW-1:0] q_lo;

  // restoring division, one quotient bit a cycle
  assign rem_sh = {rem_q, quo_q[W-1]};
  assign diff   = rem_sh - {1'b0, b_q};
  assign q_lo   = CW'(quo_q);

  assign status_o.b_zero   = (b_q == '0);
  assign status_o.r_zero   = (rem_q == '0);
  assign status_o.div_last = (cnt_q == CntLast);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q     <= W'(first_value_i);
      b_q     <= W'(second_value_i);
      up_q    <= CW'(1);
      vp_q    <= '0;
      uc_q    <= '0;
      vc_q    <= CW'(1);
      steps_q <= '0;
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      quo_q <= a_q;
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (!diff[W]) begin
        rem_q <= diff[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
      cnt_q <= cnt_q + CntW'(1);
    end
    if (cmd_i.mul) begin
      // only the low coefficient bits are kept, so products wrap
      pu_q <= CW'(q_lo * uc_q);
      pv_q <= CW'(q_lo * vc_q);
    end
    if (cmd_i.upd) begin
      uc_q  <= up_q - pu_q;
      vc_q  <= vp_q - pv_q;
      up_q  <= uc_q;
      vp_q  <= vc_q;
      a_q   <= b_q;
      b_q   <= rem_q;
      quo_q <= b_q;
      rem_q <= '0;
      cnt_q <= '0;
      if (steps_q != egcd_pkg::CountMax) steps_q <= steps_q + 5'd1;
    end
    if (cmd_i.out_load) begin
      if (b_q == '0) begin
        gcd_q <= egcd_pkg::GcdW'(a_q);
        cf_q  <= up_q;
        cs_q  <= vp_q;
      end else begin
        gcd_q <= egcd_pkg::GcdW'(b_q);
        cf_q  <= uc_q;
        cs_q  <= vc_q;
      end
      sc_q <= steps_q;
    end
  end

  assign gcd_value_o   = gcd_q;
  assign coef_first_o  = cf_q;
  assign coef_second_o = cs_q;
  assign step_count_o  = sc_q;

endmodule

`default_nettype wire

// ----- src/extended_gcd_unit.sv -----
// Extended Euclid unit: gcd of two unsigned operands with Bezout
// coefficients u, v (u*first + v*second = gcd) and the division step count.
// Input channel: in_valid_i/in_ready_o with first_value_i, second_value_i.
// Output channel: out_valid_o/out_ready_i with gcd_value_o, coef_first_o,
// coef_second_o (17-bit two's complement) and step_count_o.
// One operand pair is worked on at a time; in_ready_o is high only when
// the unit is idle. Each Euclid step runs the bit-serial restoring
// divider, then the coefficient multiply, then the update; a final
// division with a zero remainder ends the run, and a zero second
// operand skips division. 16-bit operands take up to 22 steps. The
// next input beat can be taken in the cycle after the result is loaded.
// The result sits in an output register; a stalled receiver holds the
// beat there, and a finished result waits until that register is free.
// Reset clears the controller and the output valid; payload registers are
// not reset.
`default_nettype none

module extended_gcd_unit #(
  parameter int unsigned OPERAND_WIDTH = 16
) (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic in_valid_i,
  output       logic in_ready_o,
  input  wire  logic [egcd_pkg::InW-1:0] first_value_i,
  input  wire  logic [egcd_pkg::InW-1:0] second_value_i,
  output       logic out_valid_o,
  input  wire  logic out_ready_i,
  output       logic [egcd_pkg::GcdW-1:0]   gcd_value_o,
  output       logic signed [egcd_pkg::CoefW-1:0] coef_first_o,
  output       logic signed [egcd_pkg::CoefW-1:0] coef_second_o,
  output       logic [egcd_pkg::CountW-1:0] step_count_o
);

  // command and status between sequencer and datapath
  egcd_pkg::cmd_t    cmd;
  egcd_pkg::status_t status;

  egcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  egcd_datapath #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .gcd_value_o    (gcd_value_o),
    .coef_first_o   (coef_first_o),
    .coef_second_o  (coef_second_o),
    .step_count_o   (step_count_o)
  );

endmodule

`default_nettype wire

// ----- verif/extended_gcd_unit_test.sv -----
`default_nettype none

module extended_gcd_unit_test;

  localparam int unsigned InW    = egcd_pkg::InW;
  localparam int unsigned GcdW   = egcd_pkg::GcdW;
  localparam int unsigned CoefW  = egcd_pkg::CoefW;
  localparam int unsigned CountW = egcd_pkg::CountW;
  localparam logic [CountW-1:0] CountMax = egcd_pkg::CountMax;

  localparam int unsigned OperandW   = 16;
  localparam int unsigned ClkPeriod  = 10;
  localparam int unsigned RandPairs  = 1000;
  localparam int unsigned CalmTail   = 120;   // last pairs sent with no random idle bursts
  localparam int unsigned TailCycles = 500;   // > worst latency, catches stray beats
  localparam int unsigned LimitCycles = 2_000_000;
  localparam int unsigned ReportMax  = 10;

  localparam logic [63:0] OperandMask = (64'd1 << OperandW) - 64'd1;

  // One operand pair waiting to be sent. settle: hold it back until every
  // outstanding result has been drained.
  typedef struct {
    logic [InW-1:0] op_m;
    logic [InW-1:0] op_n;
    bit             settle;
  } operand_pair_t;

  typedef struct packed {
    logic [GcdW-1:0]          gcd;
    logic signed [CoefW-1:0]  u;
    logic signed [CoefW-1:0]  v;
    logic [CountW-1:0]        steps;
  } bezout_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [InW-1:0]          first_value_i = '0;
  logic [InW-1:0]          second_value_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [GcdW-1:0]         gcd_value_o;
  logic signed [CoefW-1:0] coef_first_o;
  logic signed [CoefW-1:0] coef_second_o;
  logic [CountW-1:0]       step_count_o;

  operand_pair_t  operand_pairs_q[$];
  bezout_result_t bezout_expected_q[$];

  int unsigned pairs_sent = 0;
  int unsigned mismatch_count = 0;
  int unsigned send_gap = 0;
  int unsigned ready_stall = 0;
  logic        beat_holding;
  logic        idle_on = 1'b1;
  operand_pair_t  next_pair;
  bezout_result_t got_result;
  bezout_result_t want_result;

  int unsigned fib [0:23];

  extended_gcd_unit #(
    .OPERAND_WIDTH(OperandW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .first_value_i (first_value_i),
    .second_value_i(second_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .gcd_value_o   (gcd_value_o),
    .coef_first_o  (coef_first_o),
    .coef_second_o (coef_second_o),
    .step_count_o  (step_count_o)
  );

  always begin
    #(ClkPeriod / 2) clk_i = 1'b1;
    #(ClkPeriod / 2) clk_i = 1'b0;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Iterative extended Euclid. Coefficients are carried modulo 2^64 and only
  // the low CoefW bits are kept, so intermediate wrap does no harm.
  function automatic bezout_result_t euclid_predict(input logic [InW-1:0] m,
                                                    input logic [InW-1:0] n);
    logic [63:0] a, b, q, r;
    logic [63:0] u_prev, v_prev, u_cur, v_cur, u_hold, v_hold;
    logic [CountW-1:0] steps;
    bezout_result_t res;
    a = 64'(m) & OperandMask;
    b = 64'(n) & OperandMask;
    u_prev = 64'd1;
    v_prev = 64'd0;
    u_cur  = 64'd0;
    v_cur  = 64'd1;
    steps  = '0;
    if (b == 64'd0) begin
      // zero divisor: gcd is the first operand, u = 1, v = 0
      res.gcd = a[GcdW-1:0];
      res.u   = CoefW'(1);
      res.v   = '0;
    end else begin
      r = a % b;
      while (r != 64'd0) begin
        q = a / b;
        u_hold = u_cur;
        v_hold = v_cur;
        u_cur  = u_prev - q * u_cur;
        v_cur  = v_prev - q * v_cur;
        u_prev = u_hold;
        v_prev = v_hold;
        a = b;
        b = r;
        if (steps != CountMax) steps = steps + 1'b1;
        r = a % b;
      end
      res.gcd = b[GcdW-1:0];
      res.u   = u_cur[CoefW-1:0];
      res.v   = v_cur[CoefW-1:0];
    end
    res.steps = steps;
    return res;
  endfunction

  task automatic queue_pair(input int unsigned m, input int unsigned n, input bit settle);
    operand_pair_t p;
    p.op_m   = m[InW-1:0];
    p.op_n   = n[InW-1:0];
    p.settle = settle;
    operand_pairs_q.push_back(p);
  endtask

  // Stimulus: a directed set first, then a mix of random pair shapes.
  initial begin : stimulus
    int unsigned kind, g, x, y, k;
    bit settle;
    fib[0] = 1;
    fib[1] = 1;
    for (int i = 2; i < 24; i++) fib[i] = fib[i-1] + fib[i-2];

    // zero operands, both orders and both
    queue_pair(0, 0, 1'b0);
    queue_pair(12345, 0, 1'b0);
    queue_pair(65535, 0, 1'b0);
    queue_pair(0, 1, 1'b0);
    queue_pair(0, 65535, 1'b0);
    // field extremes
    queue_pair(1, 1, 1'b0);
    queue_pair(65535, 65535, 1'b0);
    queue_pair(65535, 1, 1'b0);
    queue_pair(1, 65535, 1'b0);
    queue_pair(65534, 65535, 1'b0);
    queue_pair(65521, 65519, 1'b0);
    // first division already exact
    queue_pair(100, 25, 1'b0);
    queue_pair(32768, 1024, 1'b0);
    // second larger than first: first step just swaps
    queue_pair(25, 100, 1'b0);
    // alternating bit patterns
    queue_pair(16'hAAAA, 16'h5555, 1'b0);
    queue_pair(16'h5555, 16'hAAAA, 1'b0);
    // longest chains: consecutive Fibonacci numbers
    queue_pair(46368, 28657, 1'b0);
    queue_pair(28657, 46368, 1'b0);
    queue_pair(28657, 17711, 1'b0);
    // textbook cases with negative coefficients on either side
    queue_pair(1071, 462, 1'b0);
    queue_pair(40902, 24140, 1'b0);
    queue_pair(7, 65535, 1'b0);

    for (int i = 0; i < RandPairs; i++) begin
      settle = (i == 0) || ($urandom_range(0, 99) == 0);
      kind = $urandom_range(0, 19);
      if (kind < 8) begin
        queue_pair($urandom_range(0, 65535), $urandom_range(0, 65535), settle);
      end else if (kind < 11) begin
        // shared factor of 2 to 600, so the gcd is a multiple of it
        g = $urandom_range(2, 600);
        x = $urandom_range(0, 65535 / g);
        y = $urandom_range(0, 65535 / g);
        queue_pair(g * x, g * y, settle);
      end else if (kind < 13) begin
        // near-Fibonacci pairs, scaled where it still fits
        k = $urandom_range(10, 22);
        g = $urandom_range(1, 65535 / fib[k+1]);
        if ($urandom_range(0, 1) == 0) queue_pair(g * fib[k+1], g * fib[k], settle);
        else queue_pair(g * fib[k], g * fib[k+1], settle);
      end else if (kind < 15) begin
        // one operand an exact multiple of the other
        y = $urandom_range(1, 4000);
        x = y * $urandom_range(1, 65535 / y);
        if ($urandom_range(0, 1) == 0) queue_pair(x, y, settle);
        else queue_pair(y, x, settle);
      end else if (kind < 17) begin
        queue_pair($urandom_range(0, 31), $urandom_range(0, 31), settle);
      end else if (kind < 18) begin
        x = $urandom_range(0, 65535);
        if ($urandom_range(0, 2) == 0) queue_pair(x, x, settle);
        else if ($urandom_range(0, 1) == 0) queue_pair(x, 0, settle);
        else queue_pair(0, x, settle);
      end else begin
        queue_pair($urandom_range(60000, 65535), $urandom_range(60000, 65535), settle);
      end
    end
  end

  // Sender: presents pairs from the queue, records the prediction on each
  // accepted beat and idles in bursts. A pair marked settle waits until every
  // outstanding result is back.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      first_value_i  <= '0;
      second_value_i <= '0;
    end else begin
      beat_holding = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        bezout_expected_q.push_back(euclid_predict(first_value_i, second_value_i));
        pairs_sent++;
        beat_holding = 1'b0;
        if (idle_on && $urandom_range(0, 2) == 0) send_gap = $urandom_range(1, 18);
      end
      if (!beat_holding) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (operand_pairs_q.size() != 0 &&
                     !(operand_pairs_q[0].settle && bezout_expected_q.size() != 0)) begin
          next_pair = operand_pairs_q.pop_front();
          first_value_i  <= next_pair.op_m;
          second_value_i <= next_pair.op_n;
          beat_holding = 1'b1;
        end
      end
      in_valid_i <= beat_holding;
      // every third stretch of 150 pairs runs without idling, as does the tail
      idle_on <= (operand_pairs_q.size() > CalmTail) && ((pairs_sent / 150) % 3 != 2);
    end
  end

  // Receiver: checks each result beat against the oldest prediction and
  // stalls ready in bursts.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got_result.gcd   = gcd_value_o;
        got_result.u     = coef_first_o;
        got_result.v     = coef_second_o;
        got_result.steps = step_count_o;
        if (bezout_expected_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportMax)
            $display("%0t: result beat with nothing outstanding: %s%0d %s%0d %s%0d %s%0d",
                     $time, "gcd=", got_result.gcd, "u=", got_result.u,
                     "v=", got_result.v, "steps=", got_result.steps);
        end else begin
          want_result = bezout_expected_q.pop_front();
          if (got_result.gcd !== want_result.gcd || got_result.u !== want_result.u ||
              got_result.v !== want_result.v || got_result.steps !== want_result.steps) begin
            mismatch_count++;
            if (mismatch_count <= ReportMax) begin
              $display("%0t: mismatch: want gcd=%0d u=%0d v=%0d steps=%0d,",
                       $time, want_result.gcd, want_result.u, want_result.v,
                       want_result.steps);
              $display("    got gcd=%0d u=%0d v=%0d steps=%0d",
                       got_result.gcd, got_result.u, got_result.v, got_result.steps);
            end
          end
        end
      end
      if (ready_stall != 0) begin
        ready_stall--;
        out_ready_i <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        ready_stall = $urandom_range(0, 17);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // End of run: all pairs sent, all results back, then a quiet spell long
  // enough for any stray beat to show.
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    while (operand_pairs_q.size() != 0 || in_valid_i || bezout_expected_q.size() != 0)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0 && bezout_expected_q.size() == 0) begin
      $display("** extended_gcd_unit: PASSED **");
    end else begin
      $display("** extended_gcd_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #(ClkPeriod * LimitCycles);
    $display("** extended_gcd_unit: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
